FILE: rtl/cigar_region_extract_defines.svh
// assertion macros for the cigar region extractor
// no dependencies; included by the top level only
`ifndef CIGAR_REGION_EXTRACT_DEFINES_SVH
`define CIGAR_REGION_EXTRACT_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define CRE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cre: implication failed");

// next-cycle implication with an explicit disable term
`define CRE_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("cre: next-cycle check failed");

`endif

FILE: rtl/cre_pkg.sv
// shared types, codes and helpers for the cigar region extractor
// no dependencies
`default_nettype none
package cre_pkg;

   localparam int unsigned POS_W = 31;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [2:0] OP_MATCH    = 3'd0;
   localparam logic [2:0] OP_MISMATCH = 3'd1;
   localparam logic [2:0] OP_INSERT   = 3'd2;
   localparam logic [2:0] OP_DELETE   = 3'd3;

   localparam logic [1:0] ST_EXTRACTED   = 2'd0;
   localparam logic [1:0] ST_NOT_SPANNING = 2'd1;
   localparam logic [1:0] ST_INVALID_OP  = 2'd2;
   localparam logic [1:0] ST_RAN_OUT     = 2'd3;

   localparam logic KIND_BASE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic REG_REGION_BEGIN  = 1'b0;
   localparam logic REG_REGION_FINISH = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ACTIVE = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [POS_W-1:0] read_begin;
      logic [POS_W-1:0] read_finish;
      logic             first_column;
      logic             final_column;
      logic [2:0]       op_code;
      logic [7:0]       aligned_char;
   } req_word_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] out_base;
      logic [1:0] status_code;
      logic       last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic         has_word1;
      rsp_word_type word0;
      rsp_word_type word1;
   } rsp_pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic rsp_word_type make_base(input logic [7:0] c);
      rsp_word_type w;
      w.result_kind = KIND_BASE;
      w.out_base    = to_upper(c);
      w.status_code = ST_EXTRACTED;
      w.last_of_run = 1'b0;
      return w;
   endfunction

   function automatic rsp_word_type make_end(input logic [1:0] st);
      rsp_word_type w;
      w.result_kind = KIND_END;
      w.out_base    = 8'd0;
      w.status_code = st;
      w.last_of_run = 1'b0;
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/cigar_region_extract.sv
// top level of the cigar region extractor: front, queue and back parts
// depends on cre_pkg, cre_front, cre_queue, cre_back and the defines header
`default_nettype none
`include "cigar_region_extract_defines.svh"
// One alignment column is taken per cycle while req_full is low; the front
// part tracks the reference position and classifies the column in that
// cycle, so columns stream back to back. A column yields zero, one or two
// result words, queued as one entry in a QUEUE_DEPTH-entry queue; the back
// part hands out one word per cycle while rsp_pop is high, so a column with
// two words takes two pops on the result side. A result word is written
// into the queue at the accepting edge and then loaded into the back part's
// output register, after which it shows on rsp_word with rsp_empty low.
module cigar_region_extract import cre_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_addr,
   input  wire logic [POS_W-1:0] csr_wdata,
   input  wire logic             req_push,
   input  wire req_word_type     req_word,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rsp_word_type          rsp_word
);

   queue_status_type q_stat;
   logic             q_push, q_pop;
   rsp_pair_type     q_pair, q_head;

   cre_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_pair    (q_pair)
   );

   cre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_pair (q_pair),
      .pop       (q_pop),
      .head_pair (q_head),
      .stat      (q_stat)
   );

   cre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   `CRE_ASSERT_IMPLY(a_no_overflow, clock, reset, q_push, !q_stat.full)
   `CRE_ASSERT_IMPLY(a_no_underflow, clock, reset, q_pop, !q_stat.empty)
   `CRE_ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, rsp_empty && q_stat.empty)

endmodule
`default_nettype wire

FILE: rtl/cre_front.sv
// front part: region registers, position tracking and column classification
// depends on cre_pkg; pushes result pairs into cre_queue
`default_nettype none
module cre_front import cre_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_addr,
   input  wire logic [POS_W-1:0] csr_wdata,
   input  wire logic             req_push,
   input  wire req_word_type     req_word,
   output logic                  req_full,
   input  wire queue_status_type q_stat,
   output logic                  q_push,
   output rsp_pair_type          q_pair
);

   logic [POS_W-1:0] region_begin_ff;
   logic [POS_W-1:0] region_finish_ff;
   logic [POS_W:0]   pos_ff, pos_in;
   phase_type        phase_ff, phase_in;

   logic           accept;
   logic           spans, reject, active;
   logic [POS_W:0] pos_eff, pos_inc;
   logic           at_end, in_region, past_end;
   logic           is_ins, is_mm, is_del;

   // classification of the current column
   logic           main_valid, main_is_end, ended, advance, ran_out;
   logic [1:0]     main_status;

   assign req_full = q_stat.full;
   assign accept   = req_push && !q_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_begin_ff  <= '0;
         region_finish_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            REG_REGION_BEGIN:  region_begin_ff  <= csr_wdata;
            REG_REGION_FINISH: region_finish_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign spans  = (req_word.read_begin < region_begin_ff) &&
                   (req_word.read_finish > region_finish_ff);
   assign reject = req_word.first_column && !spans;
   assign active = req_word.first_column ? spans : (phase_ff == PHASE_ACTIVE);

   assign pos_eff   = req_word.first_column ? {1'b0, req_word.read_begin} : pos_ff;
   assign pos_inc   = pos_eff + 1'b1;
   assign at_end    = pos_eff == {1'b0, region_finish_ff};
   assign in_region = pos_eff >= {1'b0, region_begin_ff};
   assign past_end  = pos_eff > {1'b0, region_finish_ff};

   assign is_ins = req_word.op_code == OP_INSERT;
   assign is_mm  = (req_word.op_code == OP_MATCH) || (req_word.op_code == OP_MISMATCH);
   assign is_del = req_word.op_code == OP_DELETE;

   always_comb begin
      main_valid  = 1'b0;
      main_is_end = 1'b0;
      main_status = ST_EXTRACTED;
      ended       = 1'b0;
      advance     = 1'b0;
      if (at_end) begin
         main_valid = 1'b1;
         if (!is_ins) begin
            main_is_end = 1'b1;
            ended       = 1'b1;
         end
      end else if (in_region) begin
         if (is_mm) begin
            main_valid = 1'b1;
            advance    = 1'b1;
         end else if (is_ins) begin
            main_valid = 1'b1;
         end else if (is_del) begin
            advance = 1'b1;
         end else begin
            main_valid  = 1'b1;
            main_is_end = 1'b1;
            main_status = ST_INVALID_OP;
            ended       = 1'b1;
         end
      end else if (past_end) begin
         main_valid  = 1'b1;
         main_is_end = 1'b1;
         main_status = ST_INVALID_OP;
         ended       = 1'b1;
      end else begin
         advance = !is_ins;
      end
   end

   assign ran_out = req_word.final_column && !ended;

   // next state
   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (reject) begin
            pos_in   = pos_eff;
            phase_in = PHASE_DONE;
         end else if (active) begin
            pos_in   = advance ? pos_inc : pos_eff;
            phase_in = (ended || ran_out) ? PHASE_DONE : PHASE_ACTIVE;
         end
      end
   end

   // outputs
   always_comb begin
      q_push         = 1'b0;
      q_pair.has_word1 = 1'b0;
      q_pair.word0   = make_base(req_word.aligned_char);
      q_pair.word1   = make_end(ST_RAN_OUT);
      if (accept) begin
         if (reject) begin
            q_push       = 1'b1;
            q_pair.word0 = make_end(ST_NOT_SPANNING);
         end else if (active) begin
            if (main_valid) begin
               q_push = 1'b1;
               if (main_is_end) begin
                  q_pair.word0 = make_end(main_status);
               end
               q_pair.has_word1 = ran_out;
            end else if (ran_out) begin
               q_push       = 1'b1;
               q_pair.word0 = make_end(ST_RAN_OUT);
            end
         end
      end
      q_pair.word0.last_of_run = !q_pair.has_word1;
      q_pair.word1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PHASE_IDLE;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/cre_queue.sv
// short queue of result pairs between the front and back parts
// depends on cre_pkg
`default_nettype none
module cre_queue import cre_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rsp_pair_type     push_pair,
   input  wire logic             pop,
   output rsp_pair_type          head_pair,
   output queue_status_type      stat
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   rsp_pair_type  slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = count_ff == CW'(DEPTH);
   assign stat.empty = count_ff == '0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_pair  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/cre_back.sv
// back part: output register that hands out one result word per pop
// depends on cre_pkg; drains cre_queue
`default_nettype none
module cre_back import cre_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_stat,
   input  wire rsp_pair_type     q_head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rsp_word_type          rsp_word
);

   logic         valid_ff, valid_in;
   logic         sel_ff, sel_in;
   rsp_pair_type pair_ff, pair_in;
   logic         take_next;

   assign rsp_empty = !valid_ff;
   assign rsp_word  = sel_ff ? pair_ff.word1 : pair_ff.word0;

   assign take_next = !valid_ff || (rsp_pop && (sel_ff || !pair_ff.has_word1));
   assign q_pop     = take_next && !q_stat.empty;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      pair_in  = pair_ff;
      if (take_next) begin
         valid_in = !q_stat.empty;
         sel_in   = 1'b0;
         if (!q_stat.empty) begin
            pair_in = q_head;
         end
      end else if (rsp_pop) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

endmodule
`default_nettype wire
